>>> design/mvs_pkg.sv
// Package for the matrix-vector multiply block with row statistics.
// Holds widths, the command codes and the result record; no dependencies.
package mvs_pkg;

  localparam int MAX_DIM    = 1024;
  localparam int VALUE_BITS = 16;
  localparam int IDX_BITS   = $clog2(MAX_DIM);
  localparam int SIZE_BITS  = IDX_BITS + 1;
  localparam int PROD_BITS  = 2 * VALUE_BITS;
  localparam int ACC_BITS   = 42;
  localparam int SUM_BITS   = 52;
  localparam int OUT_DEPTH  = 8;
  localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_BITS = OUT_PTR_BITS + 1;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_MATRIX = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [IDX_BITS-1:0]        row_index;
    logic signed [ACC_BITS-1:0] row_result;
    logic signed [ACC_BITS-1:0] running_max;
    logic signed [ACC_BITS-1:0] running_min;
    logic signed [SUM_BITS-1:0] running_sum;
    logic                       final_row;
  } result_t;

endpackage

>>> design/mvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mvs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/matrix_vector_multiply_stats_unit.sv
// Top level of the matrix-vector multiply block with running row statistics.
// Depends on mvs_pkg and mvs_ram (vector store).
//
//   channel  valid      ready      payload
//   cfg      cfg_valid  cfg_ready  matrix_size
//   in       in_valid   in_ready   command, vector_index, value
//   out      out_valid  out_ready  row_index, row_result, running_max,
//                                  running_min, running_sum, final_row
//
// One item per cycle while in_ready is high. A row result is written into the
// output queue via vector store read, multiply, accumulate and statistics.
// Reset is synchronous; the vector store is not cleared and holds garbage until
// loaded. The 8-entry result queue absorbs output stalls; in_ready drops only
// when queued plus in-flight row results fill it. cfg_ready is always high.
module matrix_vector_multiply_stats_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mvs_pkg::SIZE_BITS-1:0]         matrix_size,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  command,
  input  logic [mvs_pkg::IDX_BITS-1:0]          vector_index,
  input  logic signed [mvs_pkg::VALUE_BITS-1:0] value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [mvs_pkg::IDX_BITS-1:0]          row_index,
  output logic signed [mvs_pkg::ACC_BITS-1:0]   row_result,
  output logic signed [mvs_pkg::ACC_BITS-1:0]   running_max,
  output logic signed [mvs_pkg::ACC_BITS-1:0]   running_min,
  output logic signed [mvs_pkg::SUM_BITS-1:0]   running_sum,
  output logic                                  final_row
);

  localparam int IW = mvs_pkg::IDX_BITS;
  localparam int SW = mvs_pkg::SIZE_BITS;
  localparam int VW = mvs_pkg::VALUE_BITS;
  localparam int PW = mvs_pkg::PROD_BITS;
  localparam int AW = mvs_pkg::ACC_BITS;
  localparam int UW = mvs_pkg::SUM_BITS;
  localparam int QD = mvs_pkg::OUT_DEPTH;
  localparam int QP = mvs_pkg::OUT_PTR_BITS;
  localparam int QC = mvs_pkg::OUT_CNT_BITS;

  // configuration and counters
  logic [SW-1:0] size_reg;
  logic [IW-1:0] last_idx;
  logic [IW-1:0] row_counter;
  logic [IW-1:0] column_counter;
  logic          in_fire;
  logic          is_matrix;
  logic          col_end;
  logic          row_last;
  logic          load_we;

  // pipeline
  logic                 s1_valid, s1_end, s1_last;
  logic [IW-1:0]        s1_row;
  logic signed [VW-1:0] s1_value;
  logic [VW-1:0]        vec_rdata;
  logic                 s2_valid, s2_end, s2_last;
  logic [IW-1:0]        s2_row;
  logic signed [PW-1:0] s2_prod;
  logic signed [AW-1:0] row_accumulator;
  logic signed [AW-1:0] acc_sum;
  logic                 s3_end, s3_last;
  logic [IW-1:0]        s3_row;
  logic signed [AW-1:0] s3_result;

  // statistics
  logic signed [AW-1:0] max_so_far, min_so_far, max_next, min_next;
  logic signed [UW-1:0] sum_so_far, sum_next;
  logic                 first_row;

  // result queue
  mvs_pkg::result_t queue [QD];
  mvs_pkg::result_t queue_head;
  logic [QP-1:0]    wr_ptr, rd_ptr;
  logic [QC-1:0]    q_count;
  logic [QC-1:0]    pending;
  logic             out_fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= SW'(mvs_pkg::MAX_DIM);
    end else if (cfg_valid && cfg_ready) begin
      size_reg <= matrix_size;
    end
  end

  always_comb begin
    if (size_reg == '0) begin
      last_idx = '0;
    end else if (size_reg > SW'(mvs_pkg::MAX_DIM)) begin
      last_idx = IW'(mvs_pkg::MAX_DIM - 1);
    end else begin
      last_idx = IW'(size_reg - SW'(1));
    end
  end

  assign pending  = q_count + QC'(s1_valid && s1_end) + QC'(s2_valid && s2_end) + QC'(s3_end);
  assign in_ready = (pending < QC'(QD));
  assign in_fire  = in_valid && in_ready;
  assign is_matrix = (command == mvs_pkg::CMD_MATRIX);
  assign col_end  = (column_counter >= last_idx);
  assign row_last = (row_counter >= last_idx);
  assign load_we  = in_fire && !is_matrix && ({1'b0, vector_index} < SW'(mvs_pkg::MAX_DIM));

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter    <= '0;
      column_counter <= '0;
    end else if (in_fire && is_matrix) begin
      if (col_end) begin
        column_counter <= '0;
        row_counter    <= row_last ? '0 : row_counter + IW'(1);
      end else begin
        column_counter <= column_counter + IW'(1);
      end
    end
  end

  mvs_ram #(
    .WIDTH (VW),
    .DEPTH (mvs_pkg::MAX_DIM)
  ) u_vector_store (
    .clk   (clk),
    .we    (load_we),
    .waddr (vector_index),
    .wdata (value),
    .raddr (column_counter),
    .rdata (vec_rdata)
  );

  // stage 1: vector element read, multiply; valid flags of all stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_end   <= 1'b0;
    end else begin
      s1_valid <= in_fire && is_matrix;
      s2_valid <= s1_valid;
      s3_end   <= s2_valid && s2_end;
    end
  end

  always_ff @(posedge clk) begin
    s1_end   <= col_end;
    s1_last  <= row_last;
    s1_row   <= row_counter;
    s1_value <= value;
    s2_end   <= s1_end;
    s2_last  <= s1_last;
    s2_row   <= s1_row;
    s2_prod  <= PW'(s1_value) * PW'($signed(vec_rdata));
    s3_last  <= s2_last;
    s3_row   <= s2_row;
    s3_result <= acc_sum;
  end

  // stage 2: accumulate
  assign acc_sum = row_accumulator + AW'(s2_prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_accumulator <= '0;
    end else if (s2_valid) begin
      row_accumulator <= s2_end ? '0 : acc_sum;
    end
  end

  // stage 3: statistics
  assign first_row = (s3_row == '0);

  always_comb begin
    max_next = (first_row || s3_result > max_so_far) ? s3_result : max_so_far;
    min_next = (first_row || s3_result < min_so_far) ? s3_result : min_so_far;
    sum_next = first_row ? UW'(s3_result) : sum_so_far + UW'(s3_result);
  end

  always_ff @(posedge clk) begin
    if (s3_end) begin
      max_so_far <= max_next;
      min_so_far <= min_next;
      sum_so_far <= sum_next;
      queue[wr_ptr] <= '{row_index:   s3_row,
                         row_result:  s3_result,
                         running_max: max_next,
                         running_min: min_next,
                         running_sum: sum_next,
                         final_row:   s3_last};
    end
  end

  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (s3_end) begin
        wr_ptr <= wr_ptr + QP'(1);
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + QP'(1);
      end
      q_count <= q_count + QC'(s3_end) - QC'(out_fire);
    end
  end

  assign queue_head  = queue[rd_ptr];
  assign out_valid   = (q_count != '0);
  assign row_index   = queue_head.row_index;
  assign row_result  = queue_head.row_result;
  assign running_max = queue_head.running_max;
  assign running_min = queue_head.running_min;
  assign running_sum = queue_head.running_sum;
  assign final_row   = queue_head.final_row;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QC'(QD))
    else $error("result queue over capacity");

  a_queue_space: assert property (@(posedge clk) disable iff (rst)
    s3_end |-> (q_count < QC'(QD)) || out_fire)
    else $error("row result arrives at a full queue");

  a_pass_wrap: assert property (@(posedge clk) disable iff (rst)
    (in_fire && is_matrix && col_end && row_last) |=>
      (row_counter == '0) && (column_counter == '0))
    else $error("counters not cleared after final row");

endmodule

>>> test/mvs_checker.sv
// Checker for the matrix-vector multiply block: watches the config, input and result
// channels, predicts each row result with running statistics, and compares.
// Depends on mvs_pkg for widths, command codes and the result record.
`timescale 1ns / 100ps

module mvs_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [mvs_pkg::SIZE_BITS-1:0]         matrix_size,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic                                  command,
  input  logic [mvs_pkg::IDX_BITS-1:0]          vector_index,
  input  logic signed [mvs_pkg::VALUE_BITS-1:0] value,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic [mvs_pkg::IDX_BITS-1:0]          row_index,
  input  logic signed [mvs_pkg::ACC_BITS-1:0]   row_result,
  input  logic signed [mvs_pkg::ACC_BITS-1:0]   running_max,
  input  logic signed [mvs_pkg::ACC_BITS-1:0]   running_min,
  input  logic signed [mvs_pkg::SUM_BITS-1:0]   running_sum,
  input  logic                                  final_row,
  output int                                    mismatches,
  output int                                    pending,
  output int                                    rows_checked
);

  localparam int MAX_DIM    = mvs_pkg::MAX_DIM;
  localparam int VALUE_BITS = mvs_pkg::VALUE_BITS;
  localparam int IDX_BITS   = mvs_pkg::IDX_BITS;
  localparam int SIZE_BITS  = mvs_pkg::SIZE_BITS;
  localparam int PROD_BITS  = mvs_pkg::PROD_BITS;
  localparam int ACC_BITS   = mvs_pkg::ACC_BITS;
  localparam int SUM_BITS   = mvs_pkg::SUM_BITS;

  logic signed [VALUE_BITS-1:0] vec_copy [MAX_DIM];
  logic [SIZE_BITS-1:0]         size_reg;
  logic [IDX_BITS-1:0]          col_pos;
  logic [IDX_BITS-1:0]          row_pos;
  logic signed [ACC_BITS-1:0]   row_acc;
  logic signed [ACC_BITS-1:0]   max_acc;
  logic signed [ACC_BITS-1:0]   min_acc;
  logic signed [SUM_BITS-1:0]   sum_acc;
  mvs_pkg::result_t             expected_rows [$];

  function automatic int active_dim(logic [SIZE_BITS-1:0] sz);
    if (sz == 0) return 1;
    if (sz > MAX_DIM) return MAX_DIM;
    return int'(sz);
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic accumulate_element(logic signed [VALUE_BITS-1:0] elem);
    int                          dim;
    logic signed [PROD_BITS-1:0] prod;
    mvs_pkg::result_t            row_out;
    dim = active_dim(size_reg);
    prod = PROD_BITS'(elem) * PROD_BITS'(vec_copy[col_pos]);
    row_acc = row_acc + ACC_BITS'(prod);
    if (int'(col_pos) + 1 < dim) begin
      col_pos = col_pos + IDX_BITS'(1);
      return;
    end
    if (row_pos == '0) begin
      max_acc = row_acc;
      min_acc = row_acc;
      sum_acc = SUM_BITS'(row_acc);
    end else begin
      if (row_acc > max_acc) max_acc = row_acc;
      if (row_acc < min_acc) min_acc = row_acc;
      sum_acc = sum_acc + SUM_BITS'(row_acc);
    end
    row_out.row_index   = row_pos;
    row_out.row_result  = row_acc;
    row_out.running_max = max_acc;
    row_out.running_min = min_acc;
    row_out.running_sum = sum_acc;
    row_out.final_row   = (int'(row_pos) + 1 >= dim);
    expected_rows.push_back(row_out);
    row_acc = '0;
    col_pos = '0;
    row_pos = row_out.final_row ? '0 : row_pos + IDX_BITS'(1);
  endtask

  task automatic check_row();
    mvs_pkg::result_t want;
    if (expected_rows.size() == 0) begin
      report_mismatch($sformatf("row result for row %0d with none expected", row_index));
      return;
    end
    want = expected_rows.pop_front();
    rows_checked++;
    if (row_index !== want.row_index)
      report_mismatch($sformatf("row_index got %0d, expected %0d", row_index, want.row_index));
    if (row_result !== want.row_result)
      report_mismatch($sformatf("row %0d row_result got %0d, expected %0d",
                                want.row_index, row_result, want.row_result));
    if (running_max !== want.running_max)
      report_mismatch($sformatf("row %0d running_max got %0d, expected %0d",
                                want.row_index, running_max, want.running_max));
    if (running_min !== want.running_min)
      report_mismatch($sformatf("row %0d running_min got %0d, expected %0d",
                                want.row_index, running_min, want.running_min));
    if (running_sum !== want.running_sum)
      report_mismatch($sformatf("row %0d running_sum got %0d, expected %0d",
                                want.row_index, running_sum, want.running_sum));
    if (final_row !== want.final_row)
      report_mismatch($sformatf("row %0d final_row got %0b, expected %0b",
                                want.row_index, final_row, want.final_row));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      size_reg = SIZE_BITS'(MAX_DIM);
      col_pos  = '0;
      row_pos  = '0;
      row_acc  = '0;
      max_acc  = '0;
      min_acc  = '0;
      sum_acc  = '0;
      expected_rows.delete();
    end else begin
      if (cfg_valid && cfg_ready) size_reg = matrix_size;
      if (in_valid && in_ready) begin
        if (command == mvs_pkg::CMD_LOAD) vec_copy[vector_index] = value;
        else accumulate_element(value);
      end
      if (out_valid && out_ready) check_row();
    end
    pending = expected_rows.size();
  end

endmodule

>>> test/tb_top.sv
// Testbench top for matrix_vector_multiply_stats_unit: drives loads, matrix items and
// size writes with random gaps and output stalls, and gives the verdict.
// Depends on mvs_pkg, the block itself and mvs_checker.
`timescale 1ns / 100ps

module tb_top;

  localparam int MAX_DIM      = mvs_pkg::MAX_DIM;
  localparam int VALUE_BITS   = mvs_pkg::VALUE_BITS;
  localparam int IDX_BITS     = mvs_pkg::IDX_BITS;
  localparam int SIZE_BITS    = mvs_pkg::SIZE_BITS;
  localparam int ACC_BITS     = mvs_pkg::ACC_BITS;
  localparam int SUM_BITS     = mvs_pkg::SUM_BITS;
  localparam int RANDOM_ITEMS = 800;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 500000;
  localparam logic signed [VALUE_BITS-1:0] MIN_VAL = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [VALUE_BITS-1:0] MAX_VAL = {1'b0, {(VALUE_BITS-1){1'b1}}};

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [SIZE_BITS-1:0]         matrix_size = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         command = mvs_pkg::CMD_LOAD;
  logic [IDX_BITS-1:0]          vector_index = '0;
  logic signed [VALUE_BITS-1:0] value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [IDX_BITS-1:0]          row_index;
  logic signed [ACC_BITS-1:0]   row_result;
  logic signed [ACC_BITS-1:0]   running_max;
  logic signed [ACC_BITS-1:0]   running_min;
  logic signed [SUM_BITS-1:0]   running_sum;
  logic                         final_row;

  int mismatches;
  int pending;
  int rows_checked;
  int cycle_count = 0;
  int items_sent = 0;
  int loads_sent = 0;
  int size_writes = 0;
  bit steady_input = 1'b0;
  bit long_hold_req = 1'b0;
  bit vec_loaded [MAX_DIM];
  int mirror_col = 0;
  int mirror_dim = MAX_DIM;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  matrix_vector_multiply_stats_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .matrix_size  (matrix_size),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .vector_index (vector_index),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .row_index    (row_index),
    .row_result   (row_result),
    .running_max  (running_max),
    .running_min  (running_min),
    .running_sum  (running_sum),
    .final_row    (final_row)
  );

  mvs_checker mvs_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .matrix_size  (matrix_size),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .vector_index (vector_index),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .row_index    (row_index),
    .row_result   (row_result),
    .running_max  (running_max),
    .running_min  (running_min),
    .running_sum  (running_sum),
    .final_row    (final_row),
    .mismatches   (mismatches),
    .pending      (pending),
    .rows_checked (rows_checked)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return MIN_VAL;
      1:       return MAX_VAL;
      2:       return '0;
      3:       return '1;
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  task automatic send_item(mvs_pkg::cmd_t cmd, logic [IDX_BITS-1:0] idx,
                           logic signed [VALUE_BITS-1:0] val);
    int gap;
    gap = steady_input ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    command      <= cmd;
    vector_index <= idx;
    value        <= val;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic load_entry(logic [IDX_BITS-1:0] idx, logic signed [VALUE_BITS-1:0] val);
    send_item(mvs_pkg::CMD_LOAD, idx, val);
    vec_loaded[idx] = 1'b1;
    loads_sent++;
  endtask

  // load the column's vector entry first if it has never been written
  task automatic send_element(logic signed [VALUE_BITS-1:0] val);
    if (!vec_loaded[mirror_col]) load_entry(IDX_BITS'(mirror_col), pick_value());
    send_item(mvs_pkg::CMD_MATRIX, IDX_BITS'($urandom_range(0, MAX_DIM - 1)), val);
    mirror_col = (mirror_col + 1 < mirror_dim) ? mirror_col + 1 : 0;
  endtask

  // drain results and the pipeline before touching the size register
  task automatic set_size(logic [SIZE_BITS-1:0] sz);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid   <= 1'b1;
    matrix_size <= sz;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    mirror_dim = (sz == 0) ? 1 : (sz > MAX_DIM) ? MAX_DIM : int'(sz);
    size_writes++;
  endtask

  initial begin : result_sink
    int hold;
    int r;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        for (hold = 1; hold < LONG_HOLD; hold++) @(negedge clk);
      end else begin
        r = $urandom_range(0, 15);
        if (r == 0) begin
          out_ready <= 1'b1;
          hold = $urandom_range(50, 200);
        end else if (r < 6) begin
          out_ready <= 1'b0;
          hold = pick_gap() + 1;
        end else begin
          out_ready <= 1'b1;
          hold = $urandom_range(1, 6);
        end
        repeat (hold - 1) @(negedge clk);
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("no completion within %0d cycles, %0d row results outstanding",
             CYCLE_LIMIT, pending);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int rand_start;
    int phase_count;
    int phase_len;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // reset size: a partial row of extreme values, no result yet
    for (int i = 0; i < 6; i++) load_entry(IDX_BITS'(i), MIN_VAL);
    repeat (4) send_element(MIN_VAL);

    // oversized setting acts as the full size
    set_size('1);
    repeat (2) send_element(MAX_VAL);

    // shrink with the column past its new end, then finish a row
    set_size(SIZE_BITS'(3));
    repeat (4) send_element(MIN_VAL);

    // size 1 with the row counter already past the end
    set_size(SIZE_BITS'(1));
    load_entry('0, MAX_VAL);
    load_entry(IDX_BITS'(MAX_DIM - 1), '0);
    send_element(MAX_VAL);
    send_element(MIN_VAL);
    send_element('0);
    send_element('1);

    set_size('0);
    send_element(MIN_VAL);
    send_element(VALUE_BITS'(1));

    // load mid-row, then shrink the size with the column past its new end
    set_size(SIZE_BITS'(4));
    repeat (5) send_element(pick_value());
    load_entry(IDX_BITS'(1), MIN_VAL);
    send_element(MAX_VAL);
    set_size(SIZE_BITS'(2));
    send_element(pick_value());

    rand_start = items_sent;
    phase_count = 0;
    while (items_sent - rand_start < RANDOM_ITEMS) begin
      phase_len = $urandom_range(10, 60);
      steady_input = ($urandom_range(0, 3) == 0);
      if (phase_count == 4) begin
        set_size(SIZE_BITS'(1));
        steady_input = 1'b1;
        long_hold_req = 1'b1;
        wait (!long_hold_req);
        phase_len = 40;
      end else begin
        case ($urandom_range(0, 19))
          0:       set_size('0);
          1:       set_size(SIZE_BITS'(MAX_DIM));
          2, 3:    set_size(SIZE_BITS'($urandom_range(9, 48)));
          default: set_size(SIZE_BITS'($urandom_range(1, 8)));
        endcase
      end
      repeat (phase_len) begin
        if ($urandom_range(0, 3) == 0) begin
          load_entry(IDX_BITS'($urandom_range(0, MAX_DIM - 1)), pick_value());
        end else begin
          send_element(pick_value());
        end
      end
      phase_count++;
    end
    steady_input = 1'b0;

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d input items (%0d vector loads) across %0d size settings",
             items_sent, loads_sent, size_writes);
    $display("%0d row results compared, including a %0d-cycle output hold-off",
             rows_checked, LONG_HOLD);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
